// ===== rtl/core/sattr_pkg.sv =====
// ----------------------------------------------------------------------------
// sattr_pkg
// Shared constants, types and codes for the sparse attention tile row block.
// ----------------------------------------------------------------------------
package sattr_pkg;

   // Tile and block geometry (powers of two)
   localparam int TILE_SHIFT = 6;
   localparam int TILE_ROWS  = 1 << TILE_SHIFT;
   localparam int EDGE_SHIFT = 2;
   localparam int BLOCK_EDGE = 1 << EDGE_SHIFT;

   // Field widths
   localparam int TEXT_W     = 16;
   localparam int DIM_W      = 10;
   localparam int HALF_W     = DIM_W - 1;
   localparam int TILE_NUM_W = 23;
   localparam int ROW_W      = 28;
   localparam int SIZE_W     = TILE_SHIFT + 1;
   localparam int SLOT_W     = TILE_SHIFT;
   localparam int STATUS_W   = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = TEXT_W;

   // Derived widths
   localparam int SEG_TILES_W = TEXT_W - TILE_SHIFT + 1;
   localparam int PFX_TILES_W = SEG_TILES_W + 1;
   localparam int NT_W        = DIM_W - EDGE_SHIFT + 1;
   localparam int NH_W        = HALF_W - EDGE_SHIFT + 1;
   localparam int NHW_W       = 2 * NH_W;
   localparam int NBLK_W      = NT_W + NHW_W;
   localparam int EXT_W       = EDGE_SHIFT + 1;
   localparam int PROD1_W     = DIM_W + HALF_W;
   localparam int HW_W        = 2 * HALF_W;
   localparam int DIV_CNT_W   = $clog2(TILE_NUM_W);

   // Register reset values
   localparam logic [DIM_W-1:0] FRAMES_RST = DIM_W'(1);
   localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(2);
   localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_ROWS     = 3'd0,
      CSR_AUDIO_ROWS    = 3'd1,
      CSR_LATENT_FRAMES = 3'd2,
      CSR_LATENT_HEIGHT = 3'd3,
      CSR_LATENT_WIDTH  = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_LAYOUT = 2'd1,
      ST_RANGE  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_SETUP,
      SQ_TOTAL,
      SQ_CHECK,
      SQ_PFX,
      SQ_DIV1,
      SQ_DIV2,
      SQ_VGEO,
      SQ_VROW,
      SQ_EMIT,
      SQ_ONE
   } seq_state_type;

   // Configuration view handed to the sequencer
   typedef struct packed {
      logic [TEXT_W-1:0]      text_rows;
      logic [TEXT_W-1:0]      audio_rows;
      logic [DIM_W-1:0]       frames;
      logic [HALF_W-1:0]      half_h;
      logic [HALF_W-1:0]      half_w;
      logic [SEG_TILES_W-1:0] text_tiles;
      logic [PFX_TILES_W-1:0] pfx_tile_cnt;
      logic [NT_W-1:0]        nt;
      logic [NH_W-1:0]        nh;
      logic [NH_W-1:0]        nw;
      logic                   layout_ok;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [TILE_NUM_W-1:0] dividend;
      logic [NH_W-1:0]       divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [TILE_NUM_W-1:0] quotient;
      logic [NH_W-1:0]       remainder;
   } div_res_type;

endpackage

// ===== rtl/core/sattr_ifs.sv =====
// ----------------------------------------------------------------------------
// sattr_ifs
// Request and response channel interfaces (valid/ready handshake).
// ----------------------------------------------------------------------------
interface sattr_req_if;
   logic                             valid;
   logic                             ready;
   logic [sattr_pkg::TILE_NUM_W-1:0] tile_number;

   modport source (output valid, output tile_number, input ready);
   modport sink   (input valid, input tile_number, output ready);
endinterface

interface sattr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sattr_pkg::ROW_W-1:0]    row_index;
   logic                           row_present;
   logic [sattr_pkg::SIZE_W-1:0]   tile_size;
   logic                           prefix_tile;
   logic                           slot_last;
   logic [sattr_pkg::STATUS_W-1:0] status;

   modport source (output valid, output row_index, output row_present, output tile_size,
                   output prefix_tile, output slot_last, output status, input ready);
   modport sink   (input valid, input row_index, input row_present, input tile_size,
                   input prefix_tile, input slot_last, input status, output ready);
endinterface

// ===== rtl/core/sattr_csr.sv =====
// ----------------------------------------------------------------------------
// sattr_csr
// Layout registers, layout check and tile counts derived from them.
// ----------------------------------------------------------------------------
module sattr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sattr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sattr_pkg::CSR_DATA_W-1:0]    csr_data,
   output sattr_pkg::cfg_type                  cfg
);
   import sattr_pkg::*;

   logic [TEXT_W-1:0] text_ff, audio_ff;
   logic [DIM_W-1:0]  frames_ff, height_ff, width_ff;

   logic [TEXT_W:0]   text_sum, audio_sum;
   logic [DIM_W:0]    frames_sum;
   logic [HALF_W:0]   h_sum, w_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_ff   <= '0;
         audio_ff  <= '0;
         frames_ff <= FRAMES_RST;
         height_ff <= HEIGHT_RST;
         width_ff  <= WIDTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEXT_ROWS:     text_ff   <= csr_data;
            CSR_AUDIO_ROWS:    audio_ff  <= csr_data;
            CSR_LATENT_FRAMES: frames_ff <= csr_data[DIM_W-1:0];
            CSR_LATENT_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_LATENT_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ceiling divides by power-of-two tile and edge sizes
   assign text_sum   = {1'b0, text_ff}  + (TEXT_W+1)'(TILE_ROWS - 1);
   assign audio_sum  = {1'b0, audio_ff} + (TEXT_W+1)'(TILE_ROWS - 1);
   assign frames_sum = {1'b0, frames_ff} + (DIM_W+1)'(BLOCK_EDGE - 1);
   assign h_sum      = {1'b0, height_ff[DIM_W-1:1]} + (HALF_W+1)'(BLOCK_EDGE - 1);
   assign w_sum      = {1'b0, width_ff[DIM_W-1:1]}  + (HALF_W+1)'(BLOCK_EDGE - 1);

   always_comb begin
      cfg.text_rows    = text_ff;
      cfg.audio_rows   = audio_ff;
      cfg.frames       = frames_ff;
      cfg.half_h       = height_ff[DIM_W-1:1];
      cfg.half_w       = width_ff[DIM_W-1:1];
      cfg.text_tiles   = text_sum[TEXT_W:TILE_SHIFT];
      cfg.pfx_tile_cnt = {1'b0, text_sum[TEXT_W:TILE_SHIFT]}
                       + {1'b0, audio_sum[TEXT_W:TILE_SHIFT]};
      cfg.nt           = frames_sum[DIM_W:EDGE_SHIFT];
      cfg.nh           = h_sum[HALF_W:EDGE_SHIFT];
      cfg.nw           = w_sum[HALF_W:EDGE_SHIFT];
      cfg.layout_ok    = (frames_ff != '0) && (height_ff[DIM_W-1:1] != '0)
                       && (width_ff[DIM_W-1:1] != '0) && !height_ff[0] && !width_ff[0];
   end

endmodule

// ===== rtl/core/sattr_div.sv =====
// ----------------------------------------------------------------------------
// sattr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sattr_div (
   input  logic                   clock,
   input  logic                   reset,
   input  sattr_pkg::div_cmd_type cmd,
   output sattr_pkg::div_res_type res
);
   import sattr_pkg::*;

   logic                  busy_ff, done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [TILE_NUM_W-1:0] quo_ff;
   logic [NH_W-1:0]       rem_ff, dsr_ff;

   logic [NH_W:0]         shifted, trial;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[TILE_NUM_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = !trial[NH_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= cmd.dividend;
            rem_ff  <= '0;
            dsr_ff  <= cmd.divisor;
         end else if (busy_ff) begin
            // remainder stays below the divisor, so the top bit drops
            rem_ff <= fits ? trial[NH_W-1:0] : shifted[NH_W-1:0];
            quo_ff <= {quo_ff[TILE_NUM_W-2:0], fits};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(TILE_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

// ===== rtl/core/sattr_seq.sv =====
// ----------------------------------------------------------------------------
// sattr_seq
// Request sequencer: tile decode, block geometry and slot emission.
// ----------------------------------------------------------------------------
module sattr_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  sattr_pkg::cfg_type     cfg,
   output sattr_pkg::div_cmd_type div_cmd,
   input  sattr_pkg::div_res_type div_res,
   sattr_req_if.sink              req_if,
   sattr_rsp_if.source            rsp_if
);
   import sattr_pkg::*;

   seq_state_type          state_ff, state_in;
   logic [TILE_NUM_W-1:0]  tile_ff;
   logic [NHW_W-1:0]       nhw_ff;
   logic [NBLK_W-1:0]      nblk_ff;
   status_type             status_ff;
   logic [HALF_W-1:0]      bw_ff, bh_ff;
   logic [DIM_W-1:0]       bt_ff;
   logic [EXT_W-1:0]       dx_ff, dy_ff, dz_ff;
   logic [EDGE_SHIFT-1:0]  xo_ff, yo_ff;
   logic [PROD1_W-1:0]     prod1_ff;
   logic [HW_W-1:0]        hw_ff;
   logic [ROW_W-1:0]       vbase_ff, row_ff, line_ff, plane_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic                   prefix_ff;
   logic [SLOT_W-1:0]      slot_ff;

   logic [NBLK_W-1:0]      total;
   logic                   out_of_range, in_text, in_prefix;
   logic                   rsp_fire, slot_end, present, emit;
   logic [SEG_TILES_W-1:0] pfx_idx;
   logic [TEXT_W:0]        pfx_start, pfx_left;
   logic [TEXT_W-1:0]      pfx_seg;
   logic [SIZE_W-1:0]      pfx_size;
   logic [ROW_W-1:0]       pfx_row;
   logic [PROD1_W-1:0]     vprod;
   logic [ROW_W-1:0]       vmul, next_line, next_plane;
   logic [3*EXT_W-1:0]     vcount;
   logic [SIZE_W-1:0]      vsize;
   logic [EXT_W-1:0]       xo_next, yo_next;

   function automatic logic [EXT_W-1:0] block_extent(input logic [DIM_W-1:0] limit,
                                                     input logic [DIM_W-1:0] origin);
      logic [DIM_W-1:0] diff;
      diff = limit - origin;
      return (diff >= DIM_W'(BLOCK_EDGE)) ? EXT_W'(BLOCK_EDGE) : diff[EXT_W-1:0];
   endfunction

   assign total        = NBLK_W'(cfg.pfx_tile_cnt) + nblk_ff;
   assign out_of_range = NBLK_W'(tile_ff) >= total;
   assign in_text      = tile_ff < TILE_NUM_W'(cfg.text_tiles);
   assign in_prefix    = tile_ff < TILE_NUM_W'(cfg.pfx_tile_cnt);

   // prefix tile: text or audio segment
   assign pfx_idx   = in_text ? tile_ff[SEG_TILES_W-1:0]
                              : tile_ff[SEG_TILES_W-1:0] - cfg.text_tiles;
   assign pfx_start = {pfx_idx, {TILE_SHIFT{1'b0}}};
   assign pfx_seg   = in_text ? cfg.text_rows : cfg.audio_rows;
   assign pfx_left  = {1'b0, pfx_seg} - pfx_start;
   assign pfx_size  = (pfx_left >= (TEXT_W+1)'(TILE_ROWS)) ? SIZE_W'(TILE_ROWS)
                                                           : pfx_left[SIZE_W-1:0];
   assign pfx_row   = ROW_W'(pfx_start) + (in_text ? ROW_W'(0) : ROW_W'(cfg.text_rows));

   // video block start row and size
   assign vprod  = bt_ff * cfg.half_h;
   assign vmul   = prod1_ff * cfg.half_w;
   assign vcount = dx_ff * dy_ff * dz_ff;
   assign vsize  = (vcount >= (3*EXT_W)'(TILE_ROWS)) ? SIZE_W'(TILE_ROWS)
                                                      : vcount[SIZE_W-1:0];

   assign next_line  = line_ff + ROW_W'(cfg.half_w);
   assign next_plane = plane_ff + ROW_W'(hw_ff);
   assign xo_next    = {1'b0, xo_ff} + EXT_W'(1);
   assign yo_next    = {1'b0, yo_ff} + EXT_W'(1);

   assign emit     = state_ff == SQ_EMIT;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign slot_end = slot_ff == SLOT_W'(TILE_ROWS - 1);
   assign present  = {1'b0, slot_ff} < size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_cmd  = '0;
      case (state_ff)
         SQ_IDLE: begin
            if (req_if.valid) state_in = SQ_SETUP;
         end
         SQ_SETUP: begin
            state_in = cfg.layout_ok ? SQ_TOTAL : SQ_ONE;
         end
         SQ_TOTAL: begin
            state_in = SQ_CHECK;
         end
         SQ_CHECK: begin
            if (out_of_range) begin
               state_in = SQ_ONE;
            end else if (in_prefix) begin
               state_in = SQ_PFX;
            end else begin
               state_in         = SQ_DIV1;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = tile_ff - TILE_NUM_W'(cfg.pfx_tile_cnt);
               div_cmd.divisor  = cfg.nw;
            end
         end
         SQ_DIV1: begin
            // quotient of the column split feeds the row/frame split
            if (div_res.done) begin
               state_in         = SQ_DIV2;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = div_res.quotient;
               div_cmd.divisor  = cfg.nh;
            end
         end
         SQ_DIV2: begin
            if (div_res.done) state_in = SQ_VGEO;
         end
         SQ_VGEO: state_in = SQ_VROW;
         SQ_VROW: state_in = SQ_EMIT;
         SQ_PFX:  state_in = SQ_EMIT;
         SQ_EMIT: begin
            if (rsp_fire && slot_end) state_in = SQ_IDLE;
         end
         SQ_ONE: begin
            if (rsp_fire) state_in = SQ_IDLE;
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SQ_IDLE: begin
            if (req_if.valid) tile_ff <= req_if.tile_number;
         end
         SQ_SETUP: begin
            nhw_ff    <= cfg.nh * cfg.nw;
            status_ff <= cfg.layout_ok ? ST_OK : ST_LAYOUT;
         end
         SQ_TOTAL: begin
            nblk_ff <= cfg.nt * nhw_ff;
         end
         SQ_CHECK: begin
            if (out_of_range) status_ff <= ST_RANGE;
         end
         SQ_PFX: begin
            size_ff   <= pfx_size;
            row_ff    <= pfx_row;
            prefix_ff <= 1'b1;
            slot_ff   <= '0;
         end
         SQ_DIV1: begin
            if (div_res.done)
               bw_ff <= {div_res.remainder[HALF_W-EDGE_SHIFT-1:0], {EDGE_SHIFT{1'b0}}};
         end
         SQ_DIV2: begin
            if (div_res.done) begin
               bh_ff <= {div_res.remainder[HALF_W-EDGE_SHIFT-1:0], {EDGE_SHIFT{1'b0}}};
               bt_ff <= {div_res.quotient[DIM_W-EDGE_SHIFT-1:0], {EDGE_SHIFT{1'b0}}};
            end
         end
         SQ_VGEO: begin
            dz_ff    <= block_extent(cfg.frames, bt_ff);
            dy_ff    <= block_extent(DIM_W'(cfg.half_h), DIM_W'(bh_ff));
            dx_ff    <= block_extent(DIM_W'(cfg.half_w), DIM_W'(bw_ff));
            prod1_ff <= vprod + PROD1_W'(bh_ff);
            hw_ff    <= cfg.half_h * cfg.half_w;
            vbase_ff <= ROW_W'(cfg.text_rows) + ROW_W'(cfg.audio_rows) + ROW_W'(bw_ff);
         end
         SQ_VROW: begin
            row_ff    <= vmul + vbase_ff;
            line_ff   <= vmul + vbase_ff;
            plane_ff  <= vmul + vbase_ff;
            size_ff   <= vsize;
            prefix_ff <= 1'b0;
            slot_ff   <= '0;
            xo_ff     <= '0;
            yo_ff     <= '0;
         end
         SQ_EMIT: begin
            if (rsp_fire) begin
               slot_ff <= slot_ff + SLOT_W'(1);
               if (prefix_ff) begin
                  row_ff <= row_ff + ROW_W'(1);
               end else if (xo_next < dx_ff) begin
                  xo_ff  <= xo_next[EDGE_SHIFT-1:0];
                  row_ff <= row_ff + ROW_W'(1);
               end else begin
                  xo_ff <= '0;
                  if (yo_next < dy_ff) begin
                     yo_ff   <= yo_next[EDGE_SHIFT-1:0];
                     line_ff <= next_line;
                     row_ff  <= next_line;
                  end else begin
                     // next frame of the block
                     yo_ff    <= '0;
                     plane_ff <= next_plane;
                     line_ff  <= next_plane;
                     row_ff   <= next_plane;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign req_if.ready       = state_ff == SQ_IDLE;
   assign rsp_if.valid       = emit || (state_ff == SQ_ONE);
   assign rsp_if.row_present = emit && present;
   assign rsp_if.row_index   = (emit && present) ? row_ff : '0;
   assign rsp_if.tile_size   = emit ? size_ff : '0;
   assign rsp_if.prefix_tile = emit && prefix_ff;
   assign rsp_if.slot_last   = (state_ff == SQ_ONE) || (emit && slot_end);
   assign rsp_if.status      = emit ? ST_OK : status_ff;

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_if.slot_last |=> state_ff == SQ_IDLE)
      else $error("final response did not return sequencer to idle");

   a_present_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.row_present |-> rsp_if.status == ST_OK && rsp_if.tile_size != '0)
      else $error("row present on a non-ok or empty tile");

   a_pad_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_if.row_present && !rsp_if.slot_last
      |=> rsp_if.valid && !rsp_if.row_present)
      else $error("row slot after a pad slot");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == SQ_DIV1 || state_ff == SQ_DIV2)
      else $error("divider finished outside a divide step");

endmodule

// ===== rtl/core/sparse_attention_tile_rows.sv =====
// ----------------------------------------------------------------------------
// sparse_attention_tile_rows
// Row slots of one sparse attention tile, one slot per response.
//
// A request carries a tile number and is answered with 64 responses, one per
// slot, at one per cycle while the sink is ready. Before the first slot the
// block works out tile counts in its setup, total and check states; a text or
// audio tile then passes through a prefix state. A video tile is split into
// block coordinates by the shared restoring divider, two divides followed by
// a geometry step and a row step. Invalid layouts and tile numbers past the
// end give a single response. The block takes a new request only when the
// previous one has been fully answered.
// Layout registers must be written while no request is in flight.
// ----------------------------------------------------------------------------
module sparse_attention_tile_rows (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [sattr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sattr_pkg::CSR_DATA_W-1:0] csr_data,
   sattr_req_if.sink                        req_if,
   sattr_rsp_if.source                      rsp_if
);
   import sattr_pkg::*;

   cfg_type     cfg;
   div_cmd_type div_cmd;
   div_res_type div_res;

   sattr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sattr_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   sattr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .div_cmd (div_cmd),
      .div_res (div_res),
      .req_if  (req_if),
      .rsp_if  (rsp_if)
   );

endmodule
